// ----- rtl/srca_pkg.sv -----
package srca_pkg;

   localparam int INDEX_BITS   = 20;
   localparam int CAPACITY_DEF = 4096;
   localparam int COUNT_W      = 21;
   localparam int VALUE_W      = 64;
   localparam int POS_W        = 12;
   localparam int ORD_OUT_W    = 12;
   localparam int TOTAL_W      = 13;
   localparam int REQ_KIND_W   = 2;
   localparam int REQ_DATA_W   = 120;
   localparam int RSP_USED_W   = 3 + 2 * INDEX_BITS + VALUE_W + ORD_OUT_W + 2 * TOTAL_W;
   localparam int RSP_DATA_W   = 152;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_USED_W;
   localparam int CSR_ADDR_W   = 1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1048576);

   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COL_COUNT = 1'b1;

   typedef enum logic [REQ_KIND_W-1:0] {
      REQ_ADD   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD_ROW = 3'd1,
      ST_BAD_COL = 3'd2,
      ST_FULL    = 3'd3,
      ST_BAD_POS = 3'd4
   } status_type;

endpackage

// ----- rtl/sparse_row_compress_assembler.sv -----
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: row, col, value, position; tuser: request kind
// rsp      out  rsp_tvalid/rsp_tready  tdata: status, row, col, value, ord, totals; tuser: first
// csr      in   csr_we                 csr_addr selects row_count or col_count, csr_wdata
//
// One request at a time. An add scans its table from entry 0, then moves every
// later entry up one place, one entry at a time through the single entry memory.
// A merge into an existing entry waits on the iterative double adder. Reset is
// synchronous and empties the table at once. A stalled result is held; the next
// request is taken while it waits.
module sparse_row_compress_assembler #(
   parameter int CAPACITY = srca_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_index, col_index, entry_value, read_position
   input  logic [srca_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [srca_pkg::REQ_KIND_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, row_out, col_out, value_out, row_ordinal, entry_total, row_total
   output logic [srca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // row_first
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [srca_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [srca_pkg::COUNT_W-1:0]      csr_wdata
);

   import srca_pkg::*;

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int IW     = INDEX_BITS;
   localparam int COL_LO = IW;
   localparam int VAL_LO = 2 * IW;
   localparam int ORD_LO = 2 * IW + VALUE_W;
   localparam int EW     = ORD_LO + AW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SCAN_CHK,
      S_PLACE,
      S_SHIFT,
      S_SHIFT_WR,
      S_MERGE,
      S_READ_PREV,
      S_READ_CUR,
      S_READ_DONE,
      S_RESP
   } state_type;

   state_type            state_ff;
   req_kind_type         kind_ff;
   logic [IW-1:0]        row_ff, col_ff, prev_row_ff;
   logic [VALUE_W-1:0]   val_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [COUNT_W-1:0]   row_count_ff, col_count_ff;
   logic [CW-1:0]        used_ff, rows_ff, k_ff, end_ff;
   logic                 seen_ff, prev_ok_ff;
   logic [AW-1:0]        prev_ord_ff, row_ord_ff;
   logic [EW-1:0]        hold_ff;
   status_type           st_ff;
   logic [IW-1:0]        res_row_ff, res_col_ff;
   logic [VALUE_W-1:0]   res_val_ff;
   logic                 res_first_ff;
   logic [AW-1:0]        res_ord_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_first_ff;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [EW-1:0]        mem_wdata, mem_rdata;
   logic [IW-1:0]        d_row, d_col;
   logic [AW-1:0]        d_ord;
   logic                 dadd_start, dadd_done;
   logic [VALUE_W-1:0]   dadd_sum;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   assign d_row = mem_rdata[IW-1:0];
   assign d_col = mem_rdata[VAL_LO-1:COL_LO];
   assign d_ord = mem_rdata[EW-1:ORD_LO];

   assign req_tready = (state_ff == S_IDLE);
   assign dadd_start = (state_ff == S_SCAN_CHK) && (d_row == row_ff) && (d_col == col_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      case (state_ff)
         S_SCAN: mem_raddr = k_ff[AW-1:0];
         S_SHIFT: begin
            mem_raddr = k_ff[AW-1:0] - AW'(1);
            if (k_ff == end_ff) begin
               mem_we    = 1'b1;
               mem_waddr = end_ff[AW-1:0];
               mem_wdata = {row_ord_ff, val_ff, col_ff, row_ff};
            end
         end
         S_SHIFT_WR: begin
            // move the entry up one place; later rows gain an ordinal on a new row
            mem_we    = 1'b1;
            mem_waddr = k_ff[AW-1:0];
            mem_wdata = {d_ord + AW'(!seen_ff), mem_rdata[ORD_LO-1:0]};
         end
         S_MERGE: begin
            mem_we    = dadd_done;
            mem_waddr = end_ff[AW-1:0];
            mem_wdata = {hold_ff[EW-1:ORD_LO], dadd_sum, hold_ff[VAL_LO-1:0]};
         end
         S_READ_PREV: mem_raddr = AW'(pos_ff) - AW'(1);
         S_READ_CUR:  mem_raddr = AW'(pos_ff);
         default: mem_raddr = '0;
      endcase
   end

   assign rsp_data_in = {RSP_PAD_W'(0), TOTAL_W'(rows_ff), TOTAL_W'(used_ff),
                         ORD_OUT_W'(res_ord_ff), res_val_ff, res_col_ff, res_row_ff,
                         st_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rows_ff      <= '0;
         row_count_ff <= COUNT_RESET;
         col_count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_ROW_COUNT: row_count_ff <= csr_wdata;
               CSR_COL_COUNT: col_count_ff <= csr_wdata;
               default: ;
            endcase
         end
         // the response state refills the slot itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff  <= req_kind_type'(req_tuser);
                  row_ff   <= req_tdata[IW-1:0];
                  col_ff   <= req_tdata[2*IW-1:IW];
                  val_ff   <= req_tdata[2*IW+VALUE_W-1:2*IW];
                  pos_ff   <= req_tdata[2*IW+VALUE_W+POS_W-1:2*IW+VALUE_W];
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               res_row_ff   <= '0;
               res_col_ff   <= '0;
               res_val_ff   <= '0;
               res_first_ff <= 1'b0;
               res_ord_ff   <= '0;
               case (kind_ff)
                  REQ_ADD: begin
                     if (COUNT_W'(row_ff) >= row_count_ff) begin
                        st_ff    <= ST_BAD_ROW;
                        state_ff <= S_RESP;
                     end else if (COUNT_W'(col_ff) >= col_count_ff) begin
                        st_ff    <= ST_BAD_COL;
                        state_ff <= S_RESP;
                     end else begin
                        st_ff      <= ST_OK;
                        k_ff       <= '0;
                        end_ff     <= used_ff;
                        seen_ff    <= 1'b0;
                        prev_ok_ff <= 1'b0;
                        state_ff   <= S_SCAN;
                     end
                  end
                  REQ_READ: begin
                     if (32'(pos_ff) >= 32'(used_ff)) begin
                        st_ff    <= ST_BAD_POS;
                        state_ff <= S_RESP;
                     end else begin
                        st_ff    <= ST_OK;
                        state_ff <= S_READ_PREV;
                     end
                  end
                  REQ_CLEAR: begin
                     used_ff  <= '0;
                     rows_ff  <= '0;
                     st_ff    <= ST_OK;
                     state_ff <= S_RESP;
                  end
                  default: begin
                     st_ff    <= ST_OK;
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_SCAN: begin
               state_ff <= (k_ff == used_ff) ? S_PLACE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (d_row < row_ff) begin
                  prev_ord_ff <= d_ord;
                  prev_ok_ff  <= 1'b1;
                  k_ff        <= k_ff + CW'(1);
                  state_ff    <= S_SCAN;
               end else if (d_row == row_ff) begin
                  seen_ff    <= 1'b1;
                  row_ord_ff <= d_ord;
                  if (d_col == col_ff) begin
                     hold_ff  <= mem_rdata;
                     end_ff   <= k_ff;
                     state_ff <= S_MERGE;
                  end else begin
                     k_ff     <= k_ff + CW'(1);
                     state_ff <= S_SCAN;
                  end
               end else begin
                  end_ff   <= k_ff;
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               if (used_ff == CW'(CAPACITY)) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_RESP;
               end else begin
                  if (!seen_ff) begin
                     row_ord_ff <= prev_ok_ff ? (prev_ord_ff + AW'(1)) : '0;
                  end
                  k_ff     <= used_ff;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (k_ff == end_ff) begin
                  used_ff  <= used_ff + CW'(1);
                  rows_ff  <= rows_ff + CW'(!seen_ff);
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               k_ff     <= k_ff - CW'(1);
               state_ff <= S_SHIFT;
            end
            S_MERGE: begin
               if (dadd_done) begin
                  state_ff <= S_RESP;
               end
            end
            S_READ_PREV: state_ff <= S_READ_CUR;
            S_READ_CUR: begin
               prev_row_ff <= d_row;
               state_ff    <= S_READ_DONE;
            end
            S_READ_DONE: begin
               res_row_ff   <= d_row;
               res_col_ff   <= d_col;
               res_val_ff   <= mem_rdata[ORD_LO-1:VAL_LO];
               res_ord_ff   <= d_ord;
               res_first_ff <= (pos_ff == '0) || (prev_row_ff != d_row);
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               // hold until the output slot is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= rsp_data_in;
                  rsp_first_ff <= res_first_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_first_ff;

   srca_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   srca_dadd u_dadd (
      .clock (clock),
      .reset (reset),
      .start (dadd_start),
      .a     (mem_rdata[ORD_LO-1:VAL_LO]),
      .b     (val_ff),
      .done  (dadd_done),
      .sum   (dadd_sum)
   );

   a_rows_le_entries: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= used_ff)
      else $error("row total exceeds entry total");

   a_used_in_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(CAPACITY))
      else $error("entry total beyond capacity");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP || state_ff == S_DECODE) |-> !mem_we)
      else $error("entry memory written outside an update");

   a_sum_when_merging: assert property (@(posedge clock) disable iff (reset)
      dadd_done |-> (state_ff == S_MERGE))
      else $error("adder result with no merge pending");

endmodule

// ----- rtl/srca_ram.sv -----
module srca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/srca_dadd.sv -----
module srca_dadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] sum
);

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_MASK  = 64'h0008_0000_0000_0000;
   localparam logic [11:0] EXP_INF     = 12'h7FF;
   localparam logic [11:0] FAR_SHIFT   = 12'd57;

   typedef enum logic [2:0] {
      A_IDLE,
      A_ALIGN,
      A_ADD,
      A_NORM,
      A_ROUND
   } add_state_type;

   add_state_type state_ff;
   logic          done_ff;
   logic [63:0]   sum_ff;
   logic          sx_ff, sy_ff, sgn_ff;
   logic [11:0]   e_ff, d_ff;
   logic [55:0]   mx_ff, my_ff;
   logic [56:0]   s_ff;

   logic        a_nan, b_nan, a_inf, b_inf, swap, special;
   logic [63:0] x, y;
   logic [11:0] ex, ey;
   logic [56:0] add_in;
   logic        up_in;
   logic [10:0] expf_in;
   logic [62:0] packed_in;

   always_comb begin
      a_nan   = (&a[62:52]) && (|a[51:0]);
      b_nan   = (&b[62:52]) && (|b[51:0]);
      a_inf   = (&a[62:52]) && !(|a[51:0]);
      b_inf   = (&b[62:52]) && !(|b[51:0]);
      special = a_nan || b_nan || a_inf || b_inf;
      swap    = b[62:0] > a[62:0];
      x       = swap ? b : a;
      y       = swap ? a : b;
      ex      = (x[62:52] == 11'd0) ? 12'd1 : {1'b0, x[62:52]};
      ey      = (y[62:52] == 11'd0) ? 12'd1 : {1'b0, y[62:52]};
      add_in  = (sx_ff == sy_ff) ? ({1'b0, mx_ff} + {1'b0, my_ff})
                                 : ({1'b0, mx_ff} - {1'b0, my_ff});
      // round to nearest, ties to even
      up_in     = s_ff[2] & (s_ff[1] | s_ff[0] | s_ff[3]);
      expf_in   = s_ff[55] ? e_ff[10:0] : 11'd0;
      packed_in = {expf_in, s_ff[54:3]} + 63'(up_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            A_IDLE: begin
               done_ff <= start && special;
               if (start) begin
                  if (a_nan) begin
                     sum_ff <= a | QUIET_MASK;
                  end else if (b_nan) begin
                     sum_ff <= b | QUIET_MASK;
                  end else if (a_inf && b_inf && (a[63] != b[63])) begin
                     sum_ff <= DEFAULT_NAN;
                  end else if (a_inf) begin
                     sum_ff <= a;
                  end else if (b_inf) begin
                     sum_ff <= b;
                  end else begin
                     sx_ff    <= x[63];
                     sy_ff    <= y[63];
                     e_ff     <= ex;
                     d_ff     <= ex - ey;
                     mx_ff    <= {|x[62:52], x[51:0], 3'b000};
                     my_ff    <= {|y[62:52], y[51:0], 3'b000};
                     state_ff <= A_ALIGN;
                  end
               end
            end
            A_ALIGN: begin
               done_ff <= 1'b0;
               // one bit a cycle below FAR_SHIFT, else all at once; shifted-out bits collapse into sticky
               if (d_ff == 12'd0) begin
                  state_ff <= A_ADD;
               end else if (d_ff >= FAR_SHIFT) begin
                  my_ff <= {55'd0, |my_ff};
                  d_ff  <= 12'd0;
               end else begin
                  my_ff <= {1'b0, my_ff[55:2], |my_ff[1:0]};
                  d_ff  <= d_ff - 12'd1;
               end
            end
            A_ADD: begin
               done_ff  <= 1'b0;
               s_ff     <= add_in;
               sgn_ff   <= ((add_in == 57'd0) && (sx_ff != sy_ff)) ? 1'b0 : sx_ff;
               state_ff <= A_NORM;
            end
            A_NORM: begin
               done_ff <= 1'b0;
               if (s_ff[56]) begin
                  s_ff <= {1'b0, s_ff[56:2], |s_ff[1:0]};
                  e_ff <= e_ff + 12'd1;
               end else if (!s_ff[55] && (e_ff > 12'd1) && (|s_ff)) begin
                  s_ff <= {s_ff[55:0], 1'b0};
                  e_ff <= e_ff - 12'd1;
               end else begin
                  state_ff <= A_ROUND;
               end
            end
            A_ROUND: begin
               if (e_ff == EXP_INF) begin
                  sum_ff <= {sgn_ff, 11'h7FF, 52'd0};
               end else begin
                  sum_ff <= {sgn_ff, packed_in};
               end
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

// ----- tb/sparse_row_compress_assembler_tb.sv -----
module sparse_row_compress_assembler_tb;
   import srca_pkg::*;

   // a small table so that the full case is reached in a short run
   localparam int TABLE_DEPTH = 32;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      status_type        status;
      logic [19:0]       row;
      logic [19:0]       col;
      logic [63:0]       value;
      logic              first;
      logic [11:0]       ordinal;
      logic [12:0]       entry_total;
      logic [12:0]       row_total;
   } rsp_fields_type;

   typedef struct {
      req_kind_type kind;
      logic [19:0]  row;
      logic [19:0]  col;
      logic [63:0]  value;
      logic [11:0]  pos;
      bit           typed;
      status_type   status;
      int           entry_total;
      int           row_total;
   } dir_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [REQ_KIND_W-1:0]   req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [COUNT_W-1:0]      csr_wdata;

   // model of the entry table
   logic [19:0]  tab_row [TABLE_DEPTH];
   logic [19:0]  tab_col [TABLE_DEPTH];
   logic [63:0]  tab_value [TABLE_DEPTH];
   int           tab_ord [TABLE_DEPTH];
   int           used_entries_m;
   int           used_rows_m;
   int           row_limit;
   int           col_limit;

   rsp_fields_type pending_rsp [$];
   int           errors;
   int           cycles;
   int           send_idle;
   int           recv_stall;
   bit           hold_request;
   int           hold_left;
   dir_row_type  dir_tab [23];

   sparse_row_compress_assembler #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] double_sum(logic [63:0] a, logic [63:0] b);
      return $realtobits($bitstoreal(a) + $bitstoreal(b));
   endfunction

   function automatic rsp_fields_type assemble_predict(req_kind_type kind, logic [19:0] r,
                                                       logic [19:0] c, logic [63:0] v,
                                                       logic [11:0] p);
      rsp_fields_type res;
      int start;
      int stop;
      int ord;
      int k;
      bit new_row;
      bit done;
      res = '{ST_OK, 0, 0, 0, 0, 0, 0, 0};
      done = 0;
      case (kind)
         REQ_ADD: begin
            if (int'(r) >= row_limit) begin
               res.status = ST_BAD_ROW;
            end else if (int'(c) >= col_limit) begin
               res.status = ST_BAD_COL;
            end else begin
               start = 0;
               while (start < used_entries_m && tab_row[start] < r) start++;
               stop = start;
               while (!done && stop < used_entries_m && tab_row[stop] == r) begin
                  if (tab_col[stop] == c) begin
                     tab_value[stop] = double_sum(tab_value[stop], v);
                     done = 1;
                  end else begin
                     stop++;
                  end
               end
               if (!done) begin
                  if (used_entries_m >= TABLE_DEPTH) begin
                     res.status = ST_FULL;
                  end else begin
                     new_row = (start == stop);
                     if (!new_row) ord = tab_ord[start];
                     else ord = (start > 0) ? tab_ord[start-1] + 1 : 0;
                     for (k = used_entries_m; k > stop; k--) begin
                        tab_row[k]   = tab_row[k-1];
                        tab_col[k]   = tab_col[k-1];
                        tab_value[k] = tab_value[k-1];
                        tab_ord[k]   = tab_ord[k-1] + (new_row ? 1 : 0);
                     end
                     tab_row[stop]   = r;
                     tab_col[stop]   = c;
                     tab_value[stop] = v;
                     tab_ord[stop]   = ord;
                     used_entries_m++;
                     if (new_row) used_rows_m++;
                  end
               end
            end
         end
         REQ_READ: begin
            if (int'(p) >= used_entries_m) begin
               res.status = ST_BAD_POS;
            end else begin
               res.row     = tab_row[p];
               res.col     = tab_col[p];
               res.value   = tab_value[p];
               res.first   = (p == 0) || (tab_row[p-1] != tab_row[p]);
               res.ordinal = tab_ord[p][11:0];
            end
         end
         REQ_CLEAR: begin
            used_entries_m = 0;
            used_rows_m    = 0;
         end
         default: ;
      endcase
      res.entry_total = used_entries_m[12:0];
      res.row_total   = used_rows_m[12:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   task automatic check_beat();
      rsp_fields_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("unexpected beat", rsp_tdata[63:0], 0);
      end else begin
         want = pending_rsp.pop_front();
         if (rsp_tdata[2:0] !== want.status)
            report_mismatch("status", rsp_tdata[2:0], want.status);
         if (rsp_tdata[22:3] !== want.row) report_mismatch("row_out", rsp_tdata[22:3], want.row);
         if (rsp_tdata[42:23] !== want.col) report_mismatch("col_out", rsp_tdata[42:23], want.col);
         if (rsp_tdata[106:43] !== want.value)
            report_mismatch("value_out", rsp_tdata[106:43], want.value);
         if (rsp_tdata[118:107] !== want.ordinal)
            report_mismatch("row_ordinal", rsp_tdata[118:107], want.ordinal);
         if (rsp_tdata[131:119] !== want.entry_total)
            report_mismatch("entry_total", rsp_tdata[131:119], want.entry_total);
         if (rsp_tdata[144:132] !== want.row_total)
            report_mismatch("row_total", rsp_tdata[144:132], want.row_total);
         if (rsp_tuser !== want.first) report_mismatch("row_first", rsp_tuser, want.first);
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) check_beat();
      if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_req(req_kind_type kind, logic [19:0] r, logic [19:0] c,
                           logic [63:0] v, logic [11:0] p, bit typed,
                           rsp_fields_type typed_rsp);
      rsp_fields_type pred;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, p, v, c, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = assemble_predict(kind, r, c, v, p);
      pending_rsp = {pending_rsp, (typed ? typed_rsp : pred)};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // settle for a while before the next phase
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, int value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      if (addr == CSR_ROW_COUNT) row_limit = value;
      else col_limit = value;
   endtask

   function automatic logic [63:0] rand_double();
      logic [63:0] v;
      v[63]    = $urandom_range(0, 1);
      // keep clear of infinities and NaNs so that sums stay well defined
      v[62:52] = $urandom_range(0, 2046);
      v[51:32] = $urandom_range(0, 20'hFFFFF);
      v[31:0]  = $urandom;
      return v;
   endfunction

   function automatic logic [19:0] rand_index();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 7);
      return $urandom_range(0, 20'hFFFFF);
   endfunction

   task automatic random_run(int count);
      int sel;
      int pick;
      req_kind_type kind;
      logic [19:0] r;
      logic [19:0] c;
      logic [63:0] v;
      logic [11:0] p;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) kind = REQ_ADD;
         else if (sel < 90) kind = REQ_READ;
         else if (sel < 94) kind = REQ_CLEAR;
         else kind = REQ_NONE;
         r = rand_index();
         c = rand_index();
         v = rand_double();
         // reuse a stored entry now and then for merges of similar magnitude
         if (kind == REQ_ADD && used_entries_m > 0 && $urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, used_entries_m - 1);
            r = tab_row[pick];
            c = tab_col[pick];
            v = tab_value[pick] ^ {1'b0, 11'b0, 52'($urandom)};
            if (v[62:52] == 11'h7FF) v[62] = 1'b0;
         end
         if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 12'hFFF);
         else p = $urandom_range(0, used_entries_m + 1);
         push_req(kind, r, c, v, p, 0, '{ST_OK, 0, 0, 0, 0, 0, 0, 0});
      end
   endtask

   initial begin
      rsp_fields_type t;
      errors         = 0;
      cycles         = 0;
      hold_request   = 0;
      hold_left      = 0;
      send_idle      = 0;
      recv_stall     = 0;
      used_entries_m = 0;
      used_rows_m    = 0;
      row_limit      = 1048576;
      col_limit      = 1048576;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_NONE;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_ROW_COUNT;
      csr_wdata  <= '0;

      dir_tab[0]  = '{REQ_READ,  0, 0, 0, 0, 1, ST_BAD_POS, 0, 0};
      dir_tab[1]  = '{REQ_ADD, 20'hFFFFF, 20'hFFFFF, 64'h3FF0000000000000, 0, 1, ST_OK, 1, 1};
      dir_tab[2]  = '{REQ_ADD, 20'hFFFFF, 20'hFFFFF, 64'h3FF0000000000000, 0, 1, ST_OK, 1, 1};
      dir_tab[3]  = '{REQ_READ,  0, 0, 0, 0, 0, ST_OK, 0, 0};
      dir_tab[4]  = '{REQ_READ,  0, 0, 0, 12'hFFF, 1, ST_BAD_POS, 1, 1};
      dir_tab[5]  = '{REQ_NONE,  0, 0, 0, 0, 1, ST_OK, 1, 1};
      dir_tab[6]  = '{REQ_CLEAR, 0, 0, 0, 0, 1, ST_OK, 0, 0};
      dir_tab[7]  = '{REQ_ADD, 3, 10, 64'h7FF0000000000000, 0, 1, ST_OK, 1, 1};
      dir_tab[8]  = '{REQ_ADD, 3, 10, 64'hC000000000000000, 0, 1, ST_OK, 1, 1};
      dir_tab[9]  = '{REQ_ADD, 3, 5, 64'h0000000000000001, 0, 1, ST_OK, 2, 1};
      dir_tab[10] = '{REQ_ADD, 0, 0, 64'h8000000000000000, 0, 1, ST_OK, 3, 2};
      dir_tab[11] = '{REQ_ADD, 3, 5, 64'h0000000000000001, 0, 1, ST_OK, 3, 2};
      dir_tab[12] = '{REQ_ADD, 1, 9, 64'h400921FB54442D18, 0, 1, ST_OK, 4, 3};
      dir_tab[13] = '{REQ_ADD, 0, 7, 64'hBFE0000000000000, 0, 1, ST_OK, 5, 3};
      dir_tab[14] = '{REQ_ADD, 3, 10, 64'hFFEFFFFFFFFFFFFF, 0, 1, ST_OK, 5, 3};
      for (int i = 0; i < 5; i++) begin
         dir_tab[15+i] = '{REQ_READ, 0, 0, 0, 12'(i), 0, ST_OK, 0, 0};
      end
      dir_tab[20] = '{REQ_ADD, 0, 0, 64'h0000000000000000, 0, 1, ST_OK, 5, 3};
      dir_tab[21] = '{REQ_READ, 0, 0, 0, 0, 0, ST_OK, 0, 0};
      dir_tab[22] = '{REQ_READ, 0, 0, 0, 5, 1, ST_BAD_POS, 5, 3};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no idling: directed rows at reset limits, then random with one long hold-off
      foreach (dir_tab[i]) begin
         t = '{dir_tab[i].status, 0, 0, 0, 0, 0, dir_tab[i].entry_total[12:0],
               dir_tab[i].row_total[12:0]};
         push_req(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value,
                  dir_tab[i].pos, dir_tab[i].typed, t);
      end
      hold_request = 1;
      random_run(25);
      drain();

      // sender idle, smallest limits
      send_idle = 46;
      write_reg(CSR_ROW_COUNT, 1);
      write_reg(CSR_COL_COUNT, 1);
      random_run(30);
      drain();

      // receiver stalling, narrow columns fill the table
      send_idle  = 0;
      recv_stall = 46;
      write_reg(CSR_ROW_COUNT, 1048576);
      write_reg(CSR_COL_COUNT, 7);
      random_run(35);
      drain();

      // both idle
      send_idle  = 20;
      recv_stall = 20;
      write_reg(CSR_ROW_COUNT, 5);
      write_reg(CSR_COL_COUNT, 1048576);
      random_run(30);
      drain();

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
